/* design/prs_pkg.sv */
// Package for the PLL rate selector: field widths, status and register codes,
// microcode word layout, the microcode ROM and the small divide helper.
// Has no dependencies; every other design file imports it.
package prs_pkg;

	// Field widths.
	localparam int SRC_W   = 6;
	localparam int RATE_W  = 11;
	localparam int MULT_W  = 5;
	localparam int DCODE_W = 2;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 2;

	// Search limits for the multiplier and the divider.
	localparam int MULT_LIMIT = 31;
	localparam int DIV_LIMIT  = 4;

	// Reset values of the configuration registers.
	localparam logic [SRC_W-1:0]  SOURCE_RESET = SRC_W'(12);
	localparam logic [RATE_W-1:0] MAX_RESET    = RATE_W'(200);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_SOURCE_MHZ = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_MAX_RATE   = IDX_W'(1);

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK      = STAT_W'(0);
	localparam logic [STAT_W-1:0] ST_RANGE   = STAT_W'(1);
	localparam logic [STAT_W-1:0] ST_NOMATCH = STAT_W'(2);

	// Divider codes (divider minus one).
	localparam logic [DCODE_W-1:0] DIV_BY1 = DCODE_W'(0);
	localparam logic [DCODE_W-1:0] DIV_BY2 = DCODE_W'(1);
	localparam logic [DCODE_W-1:0] DIV_BY3 = DCODE_W'(2);
	localparam logic [DCODE_W-1:0] DIV_BY4 = DCODE_W'(3);

	// Division by three as a multiply by ceil(2^11 / 3) and a shift; exact
	// for every dividend below 2^11.
	localparam int PROD_W       = 2 * RATE_W;
	localparam int RECIP_SHIFT  = 11;
	localparam logic [PROD_W-1:0] DIV3_RECIP = PROD_W'(683);

	// Sequencer steps.
	typedef enum logic [1:0] {
		S_FETCH,
		S_SCAN,
		S_DRAIN,
		S_RESULT
	} step_t;

	// What a step waits for before it may leave.
	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_IN,
		WAIT_OUT
	} wait_t;

	// Jump conditions.
	typedef enum logic [1:0] {
		COND_NONE,
		COND_RANGE,
		COND_MORE,
		COND_ALWAYS
	} cond_t;

	// One microcode word.
	typedef struct packed {
		logic  rdy;
		logic  init;
		logic  issue;
		logic  compare;
		logic  load_out;
		wait_t wt;
		cond_t cond;
		step_t target;
	} ucode_t;

	// Controls from the sequencer to the scan datapath.
	typedef struct packed {
		logic init;
		logic issue;
		logic compare;
	} prs_ctrl_t;

	// Status from the scan datapath back to the sequencer.
	typedef struct packed {
		logic              last;
		logic [RATE_W-1:0] best;
		logic [MULT_W-1:0] best_m;
		logic [DCODE_W-1:0] best_d;
	} prs_scan_t;

	// The control program.
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '{rdy: 1'b0, init: 1'b0, issue: 1'b0, compare: 1'b0, load_out: 1'b0,
			wt: WAIT_NONE, cond: COND_NONE, target: S_FETCH};
		case (step)
			S_FETCH: begin
				w.rdy    = 1'b1;
				w.init   = 1'b1;
				w.wt     = WAIT_IN;
				w.cond   = COND_RANGE;
				w.target = S_RESULT;
			end
			S_SCAN: begin
				w.issue   = 1'b1;
				w.compare = 1'b1;
				w.cond    = COND_MORE;
				w.target  = S_SCAN;
			end
			S_DRAIN: begin
				w.compare = 1'b1;
				w.cond    = COND_ALWAYS;
				w.target  = S_RESULT;
			end
			S_RESULT: begin
				w.load_out = 1'b1;
				w.wt       = WAIT_OUT;
				w.cond     = COND_ALWAYS;
				w.target   = S_FETCH;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = S_FETCH;
			end
		endcase
		return w;
	endfunction

	// floor(p / (code + 1)) for the four divider codes.
	function automatic logic [RATE_W-1:0] div_by_code(input logic [RATE_W-1:0] p,
		input logic [DCODE_W-1:0] code);
		logic [PROD_W-1:0] prod;
		logic [RATE_W-1:0] q;
		prod = PROD_W'(p) * DIV3_RECIP;
		case (code)
			DIV_BY1: q = p;
			DIV_BY2: q = p >> 1;
			DIV_BY3: q = prod[RECIP_SHIFT+RATE_W-1:RECIP_SHIFT];
			DIV_BY4: q = p >> 2;
			default: q = p;
		endcase
		return q;
	endfunction

endpackage

/* design/prs_req_if.sv */
// Request channel of the PLL rate selector: valid, ready and the requested rate.
// Depends on prs_pkg.
interface prs_req_if;
	import prs_pkg::*;

	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] target_rate;

	modport source (output valid, output target_rate, input ready);
	modport sink (input valid, input target_rate, output ready);
endinterface

/* design/prs_res_if.sv */
// Result channel of the PLL rate selector: valid, ready and the chosen setting.
// Depends on prs_pkg.
interface prs_res_if;
	import prs_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [RATE_W-1:0]  chosen_rate;
	logic [MULT_W-1:0]  multiplier;
	logic [DCODE_W-1:0] divider_code;

	modport source (output valid, output status, output chosen_rate, output multiplier,
		output divider_code, input ready);
	modport sink (input valid, input status, input chosen_rate, input multiplier,
		input divider_code, output ready);
endinterface

/* design/prs_cfg_if.sv */
// Configuration write channel of the PLL rate selector: valid, ready, index, data.
// Depends on prs_pkg.
interface prs_cfg_if;
	import prs_pkg::*;

	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [RATE_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/prs_scan_dp.sv */
// Scan datapath: walks the multiplier and divider pairs, divides one pair per
// cycle into a stage register while ctrl.issue is set, and keeps the best rate found so far.
// Depends on prs_pkg.
module prs_scan_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  prs_pkg::prs_ctrl_t        ctrl,
	input  logic [prs_pkg::SRC_W-1:0] source_mhz,
	input  logic [prs_pkg::RATE_W-1:0] max_rate,
	input  logic [prs_pkg::RATE_W-1:0] target_rate,
	output prs_pkg::prs_scan_t        scan
);
	import prs_pkg::*;

	localparam logic [MULT_W-1:0]  M_LAST = MULT_W'(MULT_LIMIT);
	localparam logic [DCODE_W-1:0] D_LAST = DCODE_W'(DIV_LIMIT - 1);

	logic [RATE_W-1:0]  target_q;
	logic [MULT_W-1:0]  m_q;
	logic [DCODE_W-1:0] d_q;
	logic [RATE_W-1:0]  prod_q;
	logic               vld_s1;
	logic [RATE_W-1:0]  rate_s1;
	logic [MULT_W-1:0]  m_s1;
	logic [DCODE_W-1:0] d_s1;
	logic [RATE_W-1:0]  best_q;
	logic [MULT_W-1:0]  best_m_q;
	logic [DCODE_W-1:0] best_d_q;
	logic               last;
	logic               better;

	assign last = (m_q == M_LAST) && (d_q == D_LAST);

	// Pair counter; prod_q tracks source_mhz * m.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			m_q      <= '0;
			d_q      <= '0;
			prod_q   <= '0;
		end else if (ctrl.init) begin
			target_q <= target_rate;
			m_q      <= MULT_W'(1);
			d_q      <= DIV_BY1;
			prod_q   <= RATE_W'(source_mhz);
		end else if (ctrl.issue) begin
			if (d_q == D_LAST) begin
				d_q    <= DIV_BY1;
				m_q    <= m_q + MULT_W'(1);
				prod_q <= prod_q + RATE_W'(source_mhz);
			end else begin
				d_q <= d_q + DCODE_W'(1);
			end
		end
	end

	// Divide stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			rate_s1 <= div_by_code(prod_q, d_q);
			m_s1    <= m_q;
			d_s1    <= d_q;
		end
	end

	// A strictly larger rate wins, so the first pair of a rate is kept.
	assign better = ctrl.compare && vld_s1 && (rate_s1 != '0) && (rate_s1 <= max_rate)
		&& (rate_s1 <= target_q) && (rate_s1 > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= '0;
			best_m_q <= '0;
			best_d_q <= '0;
		end else if (ctrl.init) begin
			best_q   <= '0;
			best_m_q <= '0;
			best_d_q <= '0;
		end else if (better) begin
			best_q   <= rate_s1;
			best_m_q <= m_s1;
			best_d_q <= d_s1;
		end
	end

	assign scan = '{last: last, best: best_q, best_m: best_m_q, best_d: best_d_q};

	// A kept rate never exceeds the request and always has a real multiplier.
	a_best_le_target: assert property (@(posedge clk) disable iff (!arst_n)
		best_q != '0 |-> best_q <= target_q)
		else $error("best rate exceeds request");
	a_best_has_m: assert property (@(posedge clk) disable iff (!arst_n)
		best_q != '0 |-> best_m_q != '0)
		else $error("best rate without multiplier");
	// Starting a request clears the running best.
	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.init |=> best_q == '0)
		else $error("best not cleared on new request");

endmodule

/* design/pll_rate_select.sv */
// PLL rate selector. A request above max_rate goes from the fetch step straight to the
// result step; any other request first runs the scan step, one divide per multiplier
// and divider pair, 124 pairs, then the compare drain step and the result load.
// The serial pair scan takes no new request until the previous result is loaded.
// A request is taken while an earlier result still waits in the output register.
// Reset: source_mhz 12, max_rate 200, sequencer at fetch, no result pending.
module pll_rate_select (
	input logic        clk,
	input logic        arst_n,
	prs_req_if.sink    req,
	prs_res_if.source  res,
	prs_cfg_if.sink    cfg
);
	import prs_pkg::*;

	step_t              step_q;
	step_t              step_d;
	ucode_t             uw;
	logic               in_xfer;
	logic               out_free;
	logic               stall;
	logic               cond_ok;
	logic               range_q;
	logic               range_in;
	logic [SRC_W-1:0]   source_q;
	logic [RATE_W-1:0]  max_q;
	prs_ctrl_t          ctrl;
	prs_scan_t          scan;
	logic               res_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [RATE_W-1:0]  rate_q;
	logic [MULT_W-1:0]  mult_q;
	logic [DCODE_W-1:0] dcode_q;
	logic               load_out;

	// Configuration registers; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= SOURCE_RESET;
			max_q    <= MAX_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_SOURCE_MHZ) begin
				source_q <= cfg.data[SRC_W-1:0];
			end else if (cfg.index == REG_MAX_RATE) begin
				max_q <= cfg.data;
			end
		end
	end

	// Microcode fetch and handshake decode.
	assign uw        = ucode_rom(step_q);
	assign req.ready = uw.rdy;
	assign in_xfer   = req.valid && uw.rdy;
	assign out_free  = !res_valid_q || res.ready;
	assign range_in  = req.target_rate > max_q;
	assign load_out  = uw.load_out && out_free;

	assign ctrl = '{init: uw.init && in_xfer, issue: uw.issue, compare: uw.compare};

	// Next step: hold while waiting, jump when the condition holds, else fall through.
	always_comb begin
		case (uw.wt)
			WAIT_IN:  stall = !in_xfer;
			WAIT_OUT: stall = !out_free;
			default:  stall = 1'b0;
		endcase
		case (uw.cond)
			COND_RANGE:  cond_ok = range_in;
			COND_MORE:   cond_ok = !scan.last;
			COND_ALWAYS: cond_ok = 1'b1;
			default:     cond_ok = 1'b0;
		endcase
		if (stall) begin
			step_d = step_q;
		end else if (cond_ok) begin
			step_d = uw.target;
		end else begin
			step_d = step_t'(step_q + 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	// Range flag of the request in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= 1'b0;
		end else if (in_xfer) begin
			range_q <= range_in;
		end
	end

	prs_scan_dp u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.source_mhz  (source_q),
		.max_rate    (max_q),
		.target_rate (req.target_rate),
		.scan        (scan)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (range_q) begin
				status_q <= ST_RANGE;
				rate_q   <= '0;
				mult_q   <= '0;
				dcode_q  <= '0;
			end else if (scan.best == '0) begin
				status_q <= ST_NOMATCH;
				rate_q   <= '0;
				mult_q   <= '0;
				dcode_q  <= '0;
			end else begin
				status_q <= ST_OK;
				rate_q   <= scan.best;
				mult_q   <= scan.best_m;
				dcode_q  <= scan.best_d;
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = status_q;
	assign res.chosen_rate  = rate_q;
	assign res.multiplier   = mult_q;
	assign res.divider_code = dcode_q;

	// A transfer in leaves the fetch step at once.
	a_xfer_leaves_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> step_q != S_FETCH)
		else $error("sequencer stayed in fetch after a request transfer");
	// An out-of-range request skips the scan.
	a_range_skips_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && range_in |=> step_q == S_RESULT)
		else $error("out-of-range request entered the scan");
	// The result step waits while the output register is still occupied.
	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == S_RESULT && res_valid_q && !res.ready |=> step_q == S_RESULT)
		else $error("result step left with output register occupied");
	// The scan only ends on the last pair.
	a_scan_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == S_SCAN && !scan.last |=> step_q == S_SCAN)
		else $error("scan ended early");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pll_rate_select: drives rate requests and register
// writes, predicts each chosen setting and compares it with the result channel.
// Depends on prs_pkg, the three channel interfaces and the pll_rate_select RTL.
module tb;
	import prs_pkg::*;

	// Expected content of one result transfer.
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [RATE_W-1:0]  rate;
		logic [MULT_W-1:0]  mult;
		logic [DCODE_W-1:0] dcode;
	} rate_pick_t;

	// Unmapped register index; the block ignores writes to it.
	localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(3);

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int IDLE_PERCENT = 12;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 600;
	localparam int CALM_FROM    = 600;
	localparam int CALM_TO      = 760;
	localparam int PHASE_ITEMS  = 110;
	localparam int PHASE_COUNT  = 10;

	logic clk = 1'b0;
	logic arst_n;

	prs_req_if req_ch ();
	prs_res_if res_ch ();
	prs_cfg_if cfg_ch ();

	pll_rate_select dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Requests waiting to be driven and settings waiting to be checked.
	logic [RATE_W-1:0] rate_queue[$];
	rate_pick_t        pick_q[$];

	// Testbench copy of the configuration registers.
	logic [SRC_W-1:0]  src_now = SOURCE_RESET;
	logic [RATE_W-1:0] max_now = MAX_RESET;

	int  reqs_queued  = 0;
	int  reqs_sent    = 0;
	int  results_seen = 0;
	int  cfg_cnt      = 0;
	int  mismatches   = 0;
	int  cycle_cnt    = 0;
	int  hold_left    = 0;
	bit  hold_used    = 1'b0;
	bit  req_took     = 1'b0;
	logic calm;

	// Neither side idles while this window of requests goes through.
	assign calm = (reqs_sent >= CALM_FROM) && (reqs_sent < CALM_TO);

	always #10 clk = ~clk;

	// Largest achievable rate at or below the request, first (m, d) pair wins.
	function automatic rate_pick_t pick_rate(input logic [RATE_W-1:0] request,
		input logic [SRC_W-1:0] src, input logic [RATE_W-1:0] ceiling);
		rate_pick_t p;
		int r;
		p = '0;
		p.status = ST_OK;
		if (request > ceiling) begin
			p.status = ST_RANGE;
			return p;
		end
		for (int m = 1; m <= MULT_LIMIT; m++) begin
			for (int d = 1; d <= DIV_LIMIT; d++) begin
				r = (int'(src) * m) / d;
				if (r != 0 && r <= int'(ceiling) && r <= int'(request) && r > int'(p.rate)) begin
					p.rate  = RATE_W'(r);
					p.mult  = MULT_W'(m);
					p.dcode = DCODE_W'(d - 1);
				end
			end
		end
		if (p.rate == 0) begin
			p.status = ST_NOMATCH;
		end
		return p;
	endfunction

	// Random request, mostly in range and often close to an achievable rate.
	function automatic logic [RATE_W-1:0] random_rate();
		int pick;
		int r;
		pick = $urandom_range(99);
		if (pick < 55) begin
			r = $urandom_range(int'(max_now), 0);
		end else if (pick < 85) begin
			r = (int'(src_now) * $urandom_range(MULT_LIMIT, 1)) / $urandom_range(DIV_LIMIT, 1);
			r = r + $urandom_range(2) - 1;
		end else begin
			r = $urandom_range(2047, 0);
		end
		if (r < 0) r = 0;
		if (r > 2047) r = 2047;
		return RATE_W'(r);
	endfunction

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < IDLE_PERCENT);
	endfunction

	task automatic note_mismatch(input string what, input int got, input int exp_val);
		$display("ERROR cycle %0d: %s got %0d, expected %0d", cycle_cnt, what, got, exp_val);
		mismatches++;
	endtask

	task automatic queue_rate(input logic [RATE_W-1:0] rate);
		rate_queue.push_back(rate);
		reqs_queued++;
	endtask

	// One register write; returns after its transfer.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
		int n;
		@(negedge clk);
		n = cfg_cnt;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(negedge clk); while (cfg_cnt == n);
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until every queued request has its result back.
	task automatic wait_idle();
		do @(negedge clk);
		while (rate_queue.size() != 0 || reqs_sent != reqs_queued || pick_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// New settings, extremes now and then, followed by a batch of random requests.
	task automatic run_random_phase(input int count);
		int sel;
		logic [RATE_W-1:0] src_val;
		logic [RATE_W-1:0] max_val;
		sel = $urandom_range(9);
		if (sel == 0) src_val = 1;
		else if (sel == 1) src_val = 63;
		else src_val = RATE_W'($urandom_range(63, 1));
		sel = $urandom_range(9);
		if (sel == 0) max_val = 1;
		else if (sel == 1) max_val = 2047;
		else max_val = RATE_W'($urandom_range(2047, 1));
		write_reg(REG_SOURCE_MHZ, src_val);
		write_reg(REG_MAX_RATE, max_val);
		for (int i = 0; i < count; i++) begin
			queue_rate(random_rate());
		end
		wait_idle();
	endtask

	// Request driver: a new item goes out once the previous one has transferred.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_took) begin
			if (rate_queue.size() != 0 && !take_break()) begin
				req_ch.valid       <= 1'b1;
				req_ch.target_rate <= rate_queue.pop_front();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result ready: random idling plus one long hold-off so the block backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (!hold_used && results_seen >= HOLD_AT) begin
			hold_used    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= !take_break();
		end
	end

	// Transfer monitor: tracks register writes, predicts each request and checks results.
	always @(posedge clk) begin : monitor
		rate_pick_t exp_pick;
		req_took <= req_ch.valid && req_ch.ready;
		if (cfg_ch.valid && cfg_ch.ready) begin
			cfg_cnt <= cfg_cnt + 1;
			if (cfg_ch.index == REG_SOURCE_MHZ) src_now <= cfg_ch.data[SRC_W-1:0];
			else if (cfg_ch.index == REG_MAX_RATE) max_now <= cfg_ch.data;
		end
		if (req_ch.valid && req_ch.ready) begin
			reqs_sent <= reqs_sent + 1;
			pick_q.push_back(pick_rate(req_ch.target_rate, src_now, max_now));
		end
		if (res_ch.valid && res_ch.ready) begin
			results_seen <= results_seen + 1;
			if (pick_q.size() == 0) begin
				note_mismatch("result with none pending, rate", int'(res_ch.chosen_rate), 0);
			end else begin
				exp_pick = pick_q.pop_front();
				if (res_ch.status !== exp_pick.status)
					note_mismatch("status", int'(res_ch.status), int'(exp_pick.status));
				if (res_ch.chosen_rate !== exp_pick.rate)
					note_mismatch("chosen_rate", int'(res_ch.chosen_rate),
						int'(exp_pick.rate));
				if (res_ch.multiplier !== exp_pick.mult)
					note_mismatch("multiplier", int'(res_ch.multiplier), int'(exp_pick.mult));
				if (res_ch.divider_code !== exp_pick.dcode)
					note_mismatch("divider_code", int'(res_ch.divider_code),
						int'(exp_pick.dcode));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.target_rate = '0;
		res_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = REG_SOURCE_MHZ;
		cfg_ch.data        = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: zero request, smallest rate, just under and over the maximum.
		queue_rate(0);
		queue_rate(1);
		queue_rate(2);
		queue_rate(3);
		queue_rate(13);
		queue_rate(199);
		queue_rate(200);
		queue_rate(201);
		queue_rate(1024);
		queue_rate(2047);
		wait_idle();

		// Largest source (upper data bits dropped) and largest maximum.
		write_reg(REG_SOURCE_MHZ, 11'h7FF);
		write_reg(REG_MAX_RATE, 11'h7FF);
		queue_rate(14);
		queue_rate(15);
		queue_rate(1953);
		queue_rate(2047);
		wait_idle();

		// Smallest source and maximum.
		write_reg(REG_SOURCE_MHZ, 1);
		write_reg(REG_MAX_RATE, 1);
		queue_rate(1);
		queue_rate(2);
		wait_idle();

		// Zero source: every rate floors to zero.
		write_reg(REG_SOURCE_MHZ, 11'h7C0);
		write_reg(REG_MAX_RATE, 200);
		queue_rate(5);
		queue_rate(200);
		wait_idle();

		// Zero maximum: nonzero requests are out of range.
		write_reg(REG_SOURCE_MHZ, 12);
		write_reg(REG_MAX_RATE, 0);
		queue_rate(0);
		queue_rate(1);
		queue_rate(2047);
		wait_idle();

		// A write to an unmapped index must leave both registers alone.
		write_reg(REG_SPARE, 11'h7FF);
		queue_rate(0);
		wait_idle();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			run_random_phase(PHASE_ITEMS);
		end

		repeat (200) @(negedge clk);
		while (pick_q.size() != 0) begin
			note_mismatch("missing result, rate", 0, int'(pick_q.pop_front().rate));
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
